@@ rtl/pfb_pkg.sv @@
// Shared constants, types and helper functions for the page framebuffer blitter.
`default_nettype none

package pfb_pkg;

  // Screen geometry and the size of the page-organised store.
  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_ROWS    = 32;
  localparam int unsigned PAGE_COUNT     = (SCREEN_ROWS + 7) / 8;
  localparam int unsigned STORE_BYTES    = SCREEN_COLUMNS * PAGE_COUNT;
  localparam int unsigned ADDR_W         = $clog2(STORE_BYTES);

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned BYTE_W  = 5;
  localparam int unsigned CFG_W   = 8;

  // Reset value of the source bitmap width and height.
  localparam logic [CFG_W-1:0] BLIT_SIZE_RST = 8'd8;

  typedef enum logic [1:0] {
    REQ_BLIT  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_DEST_X      = 2'd0,
    CFG_DEST_Y      = 2'd1,
    CFG_BLIT_WIDTH  = 2'd2,
    CFG_BLIT_HEIGHT = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_INIT      = 3'd0,
    ST_IDLE      = 3'd1,
    ST_RMW       = 3'd2,
    ST_DRAIN     = 3'd3,
    ST_READ      = 3'd4,
    ST_READ_WAIT = 3'd5,
    ST_CLEAR     = 3'd6
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sweep;
    logic issue;
    logic rd_issue;
    logic result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic rmw_last;
  } ctrl_status_t;

  // Store address of the byte that holds pixel (x, y); callers clip first.
  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    return ADDR_W'(int'(y >> 3) * SCREEN_COLUMNS + int'(x));
  endfunction

endpackage

`default_nettype wire

@@ rtl/pfb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the two ports never address the same entry here.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/pfb_ctrl.sv @@
// Controller state machine that sequences requests through the datapath.
`default_nettype none

module pfb_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire pfb_pkg::req_e         req_type_i,
  input  wire pfb_pkg::ctrl_status_t status_i,
  output logic                       busy_o,
  output pfb_pkg::ctrl_cmd_t         cmd_o
);

  import pfb_pkg::*;

  state_e state_q, state_d;

  // State register; reset starts the clearing pass over the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (req_type_i)
            REQ_BLIT, REQ_SET: state_d = ST_RMW;
            REQ_CLEAR:         state_d = ST_CLEAR;
            REQ_READ:          state_d = ST_READ;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_RMW: begin
        cmd_o.issue = 1'b1;
        if (status_i.rmw_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last modified byte is written back in this cycle.
        cmd_o.result = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cmd_o.result = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.result = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pfb_datapath.sv @@
// Datapath: configuration, blit position, read-modify-write pipe and frame store.
`default_nettype none

module pfb_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pfb_pkg::ctrl_cmd_t               cmd_i,
  output pfb_pkg::ctrl_status_t                 status_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_index_i,
  input  wire logic [pfb_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire pfb_pkg::req_e                    req_type_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]      pixel_x_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]      pixel_y_i,
  input  wire logic                             pixel_value_i,
  input  wire logic [pfb_pkg::DATA_W-1:0]       source_byte_i,
  input  wire logic [pfb_pkg::INDEX_W-1:0]      read_index_i,
  output logic                                  result_valid_o,
  output logic [pfb_pkg::DATA_W-1:0]            read_data_o,
  output logic                                  blit_done_o
);

  import pfb_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] dest_x_q, dest_y_q, width_q, height_q;

  // Blit position within the source bitmap.
  logic [CFG_W-1:0]  row_q, row_next;
  logic [BYTE_W-1:0] byte_q, byte_next;
  logic              step_done;

  // Latched request.
  req_e               op_req_q;
  logic [COORD_W-1:0] op_x_q, op_col_q, op_y_q;
  logic [DATA_W-1:0]  op_bits_q;
  logic               op_en_q, op_done_q, op_rd_ok_q;
  logic [INDEX_W-1:0] op_ridx_q;
  logic [2:0]         pix_q;

  // Write-back stage of the read-modify-write pipe.
  logic              wb_valid_q, wb_val_q;
  logic [ADDR_W-1:0] wb_addr_q;
  logic [2:0]        wb_sel_q;

  // Clearing sweep.
  logic [ADDR_W-1:0] sweep_q;
  logic              sweep_last;

  // Result registers.
  logic              result_valid_q, blit_done_q;
  logic [DATA_W-1:0] read_data_q;

  // Per-pixel signals and store ports.
  logic [COORD_W-1:0] pix_col, pix_x, blit_col_base;
  logic               pix_write;
  logic [ADDR_W-1:0]  pix_addr, ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_rdata, ram_wdata, merged;
  logic               ram_we, ram_re;
  logic [5:0]         bpr_raw, bpr, byte_inc;
  logic [CFG_W:0]     row_inc;

  // Advance of the blit position by one source byte.
  always_comb begin
    bpr_raw  = 6'((9'(width_q) + 9'd7) >> 3);
    bpr      = (bpr_raw == 6'd0) ? 6'd1 : bpr_raw;
    byte_inc = 6'(byte_q) + 6'd1;
    row_inc  = (CFG_W + 1)'(row_q) + (CFG_W + 1)'(1);
    row_next = row_q;
    if (byte_inc < bpr) begin
      byte_next = byte_inc[BYTE_W-1:0];
      step_done = 1'b0;
    end else begin
      byte_next = '0;
      if (row_inc >= (CFG_W + 1)'(height_q)) begin
        row_next  = '0;
        step_done = 1'b1;
      end else begin
        row_next  = row_inc[CFG_W-1:0];
        step_done = 1'b0;
      end
    end
  end

  assign blit_col_base = {byte_q, 3'b000};

  // Configuration registers and blit position; any write restarts the blit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      width_q  <= BLIT_SIZE_RST;
      height_q <= BLIT_SIZE_RST;
      row_q    <= '0;
      byte_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_DEST_X:      dest_x_q <= cfg_data_i;
        CFG_DEST_Y:      dest_y_q <= cfg_data_i;
        CFG_BLIT_WIDTH:  width_q  <= cfg_data_i;
        CFG_BLIT_HEIGHT: height_q <= cfg_data_i;
        default:         dest_x_q <= dest_x_q;
      endcase
      row_q  <= '0;
      byte_q <= '0;
    end else if (cmd_i.accept && req_type_i == REQ_BLIT) begin
      row_q  <= row_next;
      byte_q <= byte_next;
    end
  end

  // Request latch at the input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_req_q   <= req_type_i;
      op_ridx_q  <= read_index_i;
      op_rd_ok_q <= (INDEX_W + 1)'(read_index_i) < (INDEX_W + 1)'(STORE_BYTES);
      op_done_q  <= (req_type_i == REQ_BLIT) && step_done;
      if (req_type_i == REQ_BLIT) begin
        op_x_q    <= dest_x_q + blit_col_base;
        op_col_q  <= blit_col_base;
        op_y_q    <= dest_y_q + row_q;
        op_bits_q <= source_byte_i;
        op_en_q   <= row_q < height_q;
      end else begin
        op_x_q    <= pixel_x_i;
        op_col_q  <= '0;
        op_y_q    <= pixel_y_i;
        op_bits_q <= {{(DATA_W - 1){1'b0}}, pixel_value_i};
        op_en_q   <= 1'b1;
      end
    end
  end

  // Pixel counter within one request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (cmd_i.accept) begin
      pix_q <= '0;
    end else if (cmd_i.issue) begin
      pix_q <= pix_q + 3'd1;
    end
  end

  // Clipping of the current pixel against the bitmap shape and the screen.
  always_comb begin
    pix_col   = op_col_q + COORD_W'(pix_q);
    pix_x     = op_x_q + COORD_W'(pix_q);
    pix_write = op_en_q
             && (op_req_q == REQ_SET || pix_col < width_q)
             && ((COORD_W + 1)'(pix_x) < (COORD_W + 1)'(SCREEN_COLUMNS))
             && ((COORD_W + 1)'(op_y_q) < (COORD_W + 1)'(SCREEN_ROWS));
    pix_addr  = pixel_addr(pix_x, op_y_q);
  end

  // Write-back stage: the byte read for a pixel is modified and written next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= cmd_i.issue && pix_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      wb_addr_q <= pix_addr;
      wb_sel_q  <= op_y_q[2:0];
      wb_val_q  <= op_bits_q[pix_q];
    end
  end

  // Sweep counter for the clear and the pass after reset.
  assign sweep_last = (sweep_q == ADDR_W'(STORE_BYTES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : sweep_q + ADDR_W'(1);
    end
  end

  // Store port selection.
  always_comb begin
    merged           = ram_rdata;
    merged[wb_sel_q] = wb_val_q;
    ram_we           = cmd_i.sweep || wb_valid_q;
    ram_waddr        = cmd_i.sweep ? sweep_q : wb_addr_q;
    ram_wdata        = cmd_i.sweep ? '0 : merged;
    ram_re           = cmd_i.issue || cmd_i.rd_issue;
    ram_raddr        = cmd_i.rd_issue ? ADDR_W'(op_ridx_q) : pix_addr;
  end

  pfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result registers: one strobe cycle per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      read_data_q <= (op_req_q == REQ_READ && op_rd_ok_q) ? ram_rdata : '0;
      blit_done_q <= op_done_q;
    end
  end

  assign status_o.sweep_last = sweep_last;
  assign status_o.rmw_last   = (op_req_q == REQ_SET) || (pix_q == 3'd7);

  assign result_valid_o = result_valid_q;
  assign read_data_o    = read_data_q;
  assign blit_done_o    = blit_done_q;

endmodule

`default_nettype wire

@@ rtl/page_framebuffer_blitter_unit.sv @@
// Top level of the page framebuffer blitter: controller plus datapath.
// Blit byte: a read-modify-write per pixel on the single store port pair, then a drain;
// a new request is taken only once the block is idle again, as its result strobe shows.
// Set pixel: a read-modify-write and a drain; read byte: a read and a wait state;
// clear: one store byte per cycle. After reset a clearing pass runs with busy_o high;
// registers reset at once. The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module page_framebuffer_blitter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [pfb_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]   pixel_x_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]   pixel_y_i,
  input  wire logic                          pixel_value_i,
  input  wire logic [pfb_pkg::DATA_W-1:0]    source_byte_i,
  input  wire logic [pfb_pkg::INDEX_W-1:0]   read_index_i,
  output logic                               result_valid_o,
  output logic [pfb_pkg::DATA_W-1:0]         read_data_o,
  output logic                               blit_done_o
);

  import pfb_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  req_e         req_type;

  assign req_type = req_e'(req_type_i);

  // Sequencing of each request.
  pfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type),
    .status_i   (status),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  // Store, configuration and result path.
  pfb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_value_i  (pixel_value_i),
    .source_byte_i  (source_byte_i),
    .read_index_i   (read_index_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .blit_done_o    (blit_done_o)
  );

endmodule

`default_nettype wire

@@ verif/frame_checker.sv @@
// Checker that mirrors the page framebuffer blitter and compares every result transfer.
module frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [pfb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]                    req_type_i,
  input  logic [pfb_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [pfb_pkg::COORD_W-1:0]   pixel_y_i,
  input  logic                          pixel_value_i,
  input  logic [pfb_pkg::DATA_W-1:0]    source_byte_i,
  input  logic [pfb_pkg::INDEX_W-1:0]   read_index_i,
  input  logic                          result_valid_i,
  input  logic [pfb_pkg::DATA_W-1:0]    read_data_i,
  input  logic                          blit_done_i,
  output int                            mismatches_o,
  output int                            outstanding_o
);
  import pfb_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              blit_done;
  } result_t;

  // Mirror of the store, the blit registers and the blit position.
  logic [DATA_W-1:0] frame_mirror [0:STORE_BYTES-1];
  logic [CFG_W-1:0]  dest_x_q;
  logic [CFG_W-1:0]  dest_y_q;
  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;
  logic [7:0]        src_row_q;
  logic [BYTE_W-1:0] src_byte_q;

  // Results predicted for accepted requests, oldest first.
  result_t awaited_results [$];

  function automatic void wipe_mirror();
    for (int a = 0; a < STORE_BYTES; a++) begin
      frame_mirror[a] = '0;
    end
  endfunction

  // Pixels outside the screen are dropped; bit 0 of a byte is the top row of its page.
  function automatic void mirror_plot(input int unsigned col, input int unsigned row,
                                      input logic on);
    int unsigned addr;
    if (col >= SCREEN_COLUMNS || row >= SCREEN_ROWS) begin
      return;
    end
    addr = (row / 8) * SCREEN_COLUMNS + col;
    frame_mirror[addr][row % 8] = on;
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t seen);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("%0t: %s: expected read_data %02h blit_done %0b, got read_data %02h blit_done %0b",
               $time, what, want.read_data, want.blit_done, seen.read_data, seen.blit_done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     seen;
    result_t     want;
    int          row_bytes;
    int unsigned col;
    if (!rst_ni) begin
      wipe_mirror();
      dest_x_q      = '0;
      dest_y_q      = '0;
      width_q       = BLIT_SIZE_RST;
      height_q      = BLIT_SIZE_RST;
      src_row_q     = '0;
      src_byte_q    = '0;
      awaited_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      // A result transfer is matched against the oldest prediction.
      if (result_valid_i) begin
        seen.read_data = read_data_i;
        seen.blit_done = blit_done_i;
        if (awaited_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, seen);
        end else begin
          want = awaited_results.pop_front();
          if (want.read_data !== seen.read_data || want.blit_done !== seen.blit_done) begin
            note_mismatch("wrong result", want, seen);
          end
        end
      end

      // Any register write restarts the blit at the top left of the source.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEST_X:      dest_x_q = cfg_data_i;
          CFG_DEST_Y:      dest_y_q = cfg_data_i;
          CFG_BLIT_WIDTH:  width_q  = cfg_data_i;
          CFG_BLIT_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
        src_row_q  = '0;
        src_byte_q = '0;
      end

      // Predict the outcome of a request transfer.
      if (start_i && !busy_i) begin
        want = '0;
        case (req_type_i)
          REQ_BLIT: begin
            // A zero width still counts as one byte per row, and writes nothing.
            row_bytes = (int'(width_q) + 7) / 8;
            if (row_bytes == 0) begin
              row_bytes = 1;
            end
            if (src_row_q < height_q) begin
              for (int n = 0; n < 8; n++) begin
                col = int'(src_byte_q) * 8 + n;
                // Padding bits past the width are ignored.
                if (col < width_q) begin
                  mirror_plot((int'(dest_x_q) + col) & 255,
                              (int'(dest_y_q) + int'(src_row_q)) & 255, source_byte_i[n]);
                end
              end
            end
            if (int'(src_byte_q) + 1 < row_bytes) begin
              src_byte_q = src_byte_q + 1'b1;
            end else begin
              src_byte_q = '0;
              if (int'(src_row_q) + 1 >= int'(height_q)) begin
                src_row_q      = '0;
                want.blit_done = 1'b1;
              end else begin
                src_row_q = src_row_q + 1'b1;
              end
            end
          end
          REQ_SET: begin
            mirror_plot(int'(pixel_x_i), int'(pixel_y_i), pixel_value_i);
          end
          REQ_CLEAR: begin
            wipe_mirror();
          end
          default: begin
            if (read_index_i < STORE_BYTES) begin
              want.read_data = frame_mirror[read_index_i];
            end
          end
        endcase
        awaited_results.push_back(want);
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the framebuffer blitter testbench: clock, reset, request stimulus and verdict.
module testbench;
  import pfb_pkg::*;

  localparam int ITEM_TARGET = 650;
  localparam int MAX_STREAM  = 64;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic                cfg_we      = 1'b0;
  logic [1:0]          cfg_index   = '0;
  logic [CFG_W-1:0]    cfg_data    = '0;
  logic [1:0]          req_type    = '0;
  logic [COORD_W-1:0]  pixel_x     = '0;
  logic [COORD_W-1:0]  pixel_y     = '0;
  logic                pixel_value = 1'b0;
  logic [DATA_W-1:0]   source_byte = '0;
  logic [INDEX_W-1:0]  read_index  = '0;
  logic                result_valid;
  logic [DATA_W-1:0]   read_data;
  logic                blit_done;
  int                  mismatches;
  int                  outstanding;

  // Stimulus bookkeeping: current blit shape and how often the sender holds back.
  int                  items_sent = 0;
  int                  idle_pct   = 0;
  logic [CFG_W-1:0]    cur_x      = '0;
  logic [CFG_W-1:0]    cur_y      = '0;
  logic [CFG_W-1:0]    cur_w      = BLIT_SIZE_RST;
  logic [CFG_W-1:0]    cur_h      = BLIT_SIZE_RST;

  page_framebuffer_blitter_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .req_type_i     (req_type),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .pixel_value_i  (pixel_value),
    .source_byte_i  (source_byte),
    .read_index_i   (read_index),
    .result_valid_o (result_valid),
    .read_data_o    (read_data),
    .blit_done_o    (blit_done)
  );

  frame_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .req_type_i     (req_type),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .pixel_value_i  (pixel_value),
    .source_byte_i  (source_byte),
    .read_index_i   (read_index),
    .result_valid_i (result_valid),
    .read_data_i    (read_data),
    .blit_done_i    (blit_done),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well beyond the slowest correct run, clears and the power-up pass included.
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Presents one request from a falling edge until its transfer, then idles at random.
  // Start stays high on return if the sender did not idle, so that a following request keeps it asserted.
  task automatic send_request(input req_e kind, input logic [7:0] x, input logic [7:0] y,
                              input logic on, input logic [7:0] src,
                              input logic [INDEX_W-1:0] idx);
    start       <= 1'b1;
    req_type    <= kind;
    pixel_x     <= x;
    pixel_y     <= y;
    pixel_value <= on;
    source_byte <= src;
    read_index  <= idx;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Request with random content in every field that the operation does not use.
  task automatic send_random(input req_e kind, input logic [INDEX_W-1:0] idx);
    logic [7:0] x;
    logic [7:0] y;
    x = 8'(($urandom_range(1) != 0) ? $urandom_range(127) : $urandom_range(255));
    y = 8'(($urandom_range(3) != 0) ? $urandom_range(31) : $urandom_range(255));
    send_request(kind, x, y, 1'($urandom_range(1)), 8'($urandom_range(255)), idx);
  endtask

  // Holds the sender back until every result has come and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_setting(input cfg_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_blit(input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] w, input logic [7:0] h);
    write_setting(CFG_DEST_X, x);
    write_setting(CFG_DEST_Y, y);
    write_setting(CFG_BLIT_WIDTH, w);
    write_setting(CFG_BLIT_HEIGHT, h);
    cfg_we <= 1'b0;
    cur_x = x;
    cur_y = y;
    cur_w = w;
    cur_h = h;
  endtask

  // Reads a store byte that the current blit rectangle is likely to have touched.
  task automatic read_blit_area();
    logic [7:0] row;
    logic [7:0] col;
    row = cur_y + 8'($urandom_range((cur_h == 0) ? 0 : cur_h - 1));
    col = cur_x + 8'($urandom_range((cur_w == 0) ? 0 : cur_w - 1));
    send_random(REQ_READ, {row[4:3], col[6:0]});
  endtask

  initial begin
    int bytes_per_row;
    int stream_len;
    int scene;
    logic [7:0] sources [8];

    sources = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'hFF, 8'h3C};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset shape: corners, off-screen pixels, one 8x8 blit, clear.
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd511);
    send_request(REQ_SET, 8'd0, 8'd0, 1'b1, 8'd0, 9'd0);
    send_request(REQ_SET, 8'd127, 8'd31, 1'b1, 8'd0, 9'd0);
    send_request(REQ_SET, 8'd128, 8'd5, 1'b1, 8'hFF, 9'd0);
    send_request(REQ_SET, 8'd3, 8'd32, 1'b1, 8'hFF, 9'd0);
    send_request(REQ_SET, 8'd255, 8'd255, 1'b1, 8'hFF, 9'd511);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd511);
    send_request(REQ_SET, 8'd127, 8'd31, 1'b0, 8'd0, 9'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd511);
    for (int i = 0; i < 8; i++) begin
      send_request(REQ_BLIT, 8'd0, 8'd0, 1'b0, sources[i], 9'd0);
    end
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd2);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd256);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 8'd0, 9'd2);

    // Random scenes: mostly whole blit rectangles with random content, read back,
    // mixed with pixel writes, stray reads, rare clears and broken-off streams.
    scene = 0;
    while (items_sent < ITEM_TARGET) begin
      case ((items_sent * 4) / ITEM_TARGET)
        1:       idle_pct = 77;
        2:       idle_pct = 24;
        default: idle_pct = 0;
      endcase

      // New shapes only once the block has drained; the first few are the extremes.
      if (scene < 5 || $urandom_range(2) == 0) begin
        wait_drained();
        case (scene)
          0:       program_blit(8'd0, 8'd0, 8'd0, 8'd3);
          1:       program_blit(8'd5, 8'd2, 8'd13, 8'd0);
          2:       program_blit(8'd255, 8'd255, 8'd255, 8'd2);
          3:       program_blit(8'd120, 8'd28, 8'd1, 8'd255);
          4:       program_blit(8'd0, 8'd0, 8'd255, 8'd255);
          default: program_blit(
                     8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(127)),
                     8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(31)),
                     8'(($urandom_range(7) == 0) ? $urandom_range(255) :
                                                   $urandom_range(1, 24)),
                     8'(($urandom_range(7) == 0) ? $urandom_range(40) :
                                                   $urandom_range(1, 12)));
        endcase
      end

      bytes_per_row = (int'(cur_w) + 7) / 8;
      if (bytes_per_row == 0) begin
        bytes_per_row = 1;
      end
      stream_len = bytes_per_row * ((cur_h == 0) ? 1 : int'(cur_h));
      if (stream_len > MAX_STREAM) begin
        stream_len = MAX_STREAM;
      end

      repeat (stream_len) send_random(REQ_BLIT, 9'($urandom_range(511)));
      repeat ($urandom_range(2, 6)) read_blit_area();
      repeat ($urandom_range(4)) send_random(REQ_SET, 9'($urandom_range(511)));
      repeat ($urandom_range(2)) send_random(REQ_READ, 9'($urandom_range(511)));
      if ($urandom_range(29) == 0) begin
        send_random(REQ_CLEAR, 9'($urandom_range(511)));
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, (stream_len > 1) ? stream_len - 1 : 3)) begin
          send_random(REQ_BLIT, 9'($urandom_range(511)));
        end
        read_blit_area();
      end
      scene++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pfb_pkg.sv
rtl/pfb_ram.sv
rtl/pfb_ctrl.sv
rtl/pfb_datapath.sv
rtl/page_framebuffer_blitter_unit.sv
verif/frame_checker.sv
verif/testbench.sv
